// ===== sv/pta_pkg.sv =====
// Package with shared types, constants and opcodes of the peer table block.
`default_nettype none
package pta_pkg;
    localparam int MaxPeers  = 16;
    localparam int SlotW     = 4;
    localparam int CountW    = 5;
    localparam logic [7:0] AliveMask = 8'd1;
    localparam logic [7:0] DeadMask  = 8'd2;

    localparam logic [2:0] ModeInit   = 3'd0;
    localparam logic [2:0] ModeHb     = 3'd1;
    localparam logic [2:0] ModeSelf   = 3'd2;
    localparam logic [2:0] ModeTick   = 3'd3;
    localparam logic [2:0] ModeSeed   = 3'd4;
    localparam logic [2:0] ModeClear  = 3'd5;

    localparam logic [1:0] CfgOwnMac   = 2'd0;
    localparam logic [1:0] CfgOwnApMac = 2'd1;
    localparam logic [1:0] CfgStale    = 2'd2;
    localparam logic [1:0] CfgDelta    = 2'd3;

    // Width of one table row: mac, ap mac, battery, last seen, status.
    localparam int RowW = 48 + 48 + 16 + 32 + 8;

    typedef struct packed {
        logic [47:0] mac;
        logic [47:0] ap_mac;
        logic [15:0] battery;
        logic [31:0] last_seen;
        logic [7:0]  status;
    } row_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [47:0] peer_mac;
        logic [15:0] supply_mv;
        logic [7:0]  status_flags;
        logic        ap_mac_valid;
        logic [47:0] ap_mac;
        logic [31:0] now_ms;
        logic        seed_last;
    } item_t;

    typedef struct packed {
        logic        slot_found;
        logic [3:0]  slot_index;
        logic        new_peer;
        logic        table_full;
        logic        sync_sent;
        logic [31:0] sync_hash;
        logic        reelect_request;
        logic [4:0]  peer_count;
        logic [4:0]  alive_count;
        logic [1:0]  dimension;
        logic [15:0] entry_supply_mv;
        logic [7:0]  entry_flags;
    } result_t;
endpackage
`default_nettype wire

// ===== sv/peer_table_with_aging_unit.sv =====
// Top level of the peer table with aging: sequencer around one row memory.
//
//  channel | signals                        | handshake
//  --------+--------------------------------+-------------------------------
//  item    | start, busy, item              | taken when start && !busy
//  result  | done, result                   | one-cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_wdata   | written when cfg_we is high
//
// A transaction keeps busy high through pass A over the n slots in use before
// the update, the apply step, pass B over the n' slots after it, the final
// step and the output step. The table lives in one row memory and the
// sequencer walks it twice, slot 0 first: search or aging, then recount and
// hash. Init wipes all 16 rows, then makes the pass over slot 0.
// done pulses in the last busy cycle. Reset clears control state only; rows
// are defined once written. The result cannot be stalled.
`default_nettype none
module peer_table_with_aging_unit
    import pta_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output logic             done,
    output result_t          result,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_wdata
);
    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StWipe  = 4'd1;
    localparam logic [3:0] StScanA = 4'd2; // issue reads of pass A
    localparam logic [3:0] StApply = 4'd3; // act on search/aging
    localparam logic [3:0] StScanB = 4'd4; // recount, hash, lookup, best
    localparam logic [3:0] StFinal = 4'd5;
    localparam logic [3:0] StOut   = 4'd6;

    // Configuration registers.
    logic [47:0] own_mac_reg, own_ap_reg;
    logic [31:0] stale_reg;
    logic [15:0] delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ap_reg  <= '0;
            stale_reg   <= 32'd90000;
            delta_reg   <= 16'd200;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgOwnMac:   own_mac_reg <= cfg_wdata;
                CfgOwnApMac: own_ap_reg  <= cfg_wdata;
                CfgStale:    stale_reg   <= cfg_wdata[31:0];
                CfgDelta:    delta_reg   <= cfg_wdata[15:0];
                default:     own_mac_reg <= own_mac_reg;
            endcase
        end
    end

    // Row memory.
    logic             we;
    logic [SlotW-1:0] waddr, raddr;
    row_t             wrow, rrow;

    pta_ram #(.Width(RowW), .Depth(MaxPeers)) u_rows (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wrow),
        .raddr(raddr), .rdata(rrow)
    );

    // Control and working registers.
    logic [3:0]        st_reg, st_next;
    item_t             it_reg;
    logic [CountW-1:0] used_reg;
    logic [31:0]       last_hash_reg;
    logic [CountW-1:0] ptr_reg;       // read address being issued
    logic              rv_reg;        // read data valid for slot rs_reg
    logic [SlotW-1:0]  rs_reg;
    logic              found_reg;
    logic [SlotW-1:0]  fidx_reg;
    logic              dead_found_reg;
    logic              changed_reg;
    logic [31:0]       hash_reg;
    logic [CountW-1:0] alive_reg;
    logic [15:0]       best_reg, gw_reg;
    logic [15:0]       ebat_reg;
    logic [7:0]        eflg_reg;
    logic              newp_reg, full_reg, sync_reg;
    result_t           res_reg;
    logic              done_reg;

    logic [CountW-1:0] n_use;
    assign n_use = (used_reg > CountW'(MaxPeers)) ? CountW'(MaxPeers) : used_reg;

    logic [31:0] age;
    assign age = it_reg.now_ms - rrow.last_seen;

    logic [7:0] hb_status;
    assign hb_status = (it_reg.status_flags | AliveMask) & ~DeadMask;

    // Result assembly from pass B.
    result_t res_c;
    logic [31:0] fhash;
    logic        hash_sync;
    always_comb
    begin
        fhash = hash_reg ^ 32'(used_reg);
        hash_sync = fhash != last_hash_reg;
        res_c.slot_found       = found_reg;
        res_c.slot_index       = found_reg ? fidx_reg : '0;
        res_c.new_peer         = newp_reg;
        res_c.table_full       = full_reg;
        res_c.sync_sent        = sync_reg && hash_sync;
        res_c.sync_hash        = fhash;
        res_c.reelect_request  = (it_reg.mode == ModeTick) && (best_reg > gw_reg)
                                 && ((best_reg - gw_reg) >= delta_reg);
        res_c.peer_count       = used_reg;
        res_c.alive_count      = alive_reg;
        res_c.dimension        = (alive_reg <= 5'd2) ? 2'd1 :
                                 ((alive_reg == 5'd3) ? 2'd2 : 2'd3);
        res_c.entry_supply_mv  = found_reg ? ebat_reg : '0;
        res_c.entry_flags      = found_reg ? eflg_reg : '0;
    end

    // Sequencer and memory access.
    always_comb
    begin
        st_next = st_reg;
        we      = 1'b0;
        waddr   = rs_reg;
        wrow    = rrow;
        raddr   = ptr_reg[SlotW-1:0];
        case (st_reg)
            StWipe:
            begin
                we    = 1'b1;
                waddr = ptr_reg[SlotW-1:0];
                wrow  = '0;
                if (ptr_reg[SlotW-1:0] == '0)
                begin
                    wrow.mac       = own_mac_reg;
                    wrow.ap_mac    = own_ap_reg;
                    wrow.battery   = it_reg.supply_mv;
                    wrow.last_seen = it_reg.now_ms;
                    wrow.status    = AliveMask;
                end
                if (ptr_reg == CountW'(MaxPeers - 1))
                begin
                    st_next = StScanB;
                end
            end
            StScanA:
            begin
                // Aging writeback of the row read in the previous cycle.
                if (rv_reg && it_reg.mode == ModeTick && rs_reg != '0
                    && !(rrow.status[1]) && age > stale_reg)
                begin
                    we = 1'b1;
                    wrow.status = DeadMask;
                end
                // Past the last slot, fetch the row that the apply step merges into.
                if (ptr_reg >= n_use)
                begin
                    raddr = (it_reg.mode == ModeSelf) ? '0 : fidx_reg;
                end
                if (!rv_reg && ptr_reg >= n_use)
                begin
                    st_next = StApply;
                end
            end
            StApply:
            begin
                st_next = StScanB;
                case (it_reg.mode)
                    ModeHb:
                    begin
                        if (found_reg || used_reg < CountW'(MaxPeers))
                        begin
                            we = 1'b1;
                            waddr = found_reg ? fidx_reg : used_reg[SlotW-1:0];
                            wrow.mac       = it_reg.peer_mac;
                            wrow.ap_mac    = it_reg.ap_mac_valid ? it_reg.ap_mac :
                                             (found_reg ? rrow.ap_mac : '0);
                            wrow.battery   = it_reg.supply_mv;
                            wrow.last_seen = it_reg.now_ms;
                            wrow.status    = hb_status;
                        end
                    end
                    ModeSelf:
                    begin
                        we = 1'b1;
                        waddr = '0;
                        wrow.battery   = it_reg.supply_mv;
                        wrow.last_seen = it_reg.now_ms;
                    end
                    ModeSeed:
                    begin
                        if (it_reg.peer_mac != own_mac_reg && !it_reg.status_flags[1]
                            && !found_reg && used_reg < CountW'(MaxPeers))
                        begin
                            we = 1'b1;
                            waddr = used_reg[SlotW-1:0];
                            wrow.mac       = it_reg.peer_mac;
                            wrow.ap_mac    = it_reg.ap_mac;
                            wrow.battery   = it_reg.supply_mv;
                            wrow.last_seen = it_reg.now_ms;
                            wrow.status    = AliveMask;
                        end
                    end
                    default: we = 1'b0;
                endcase
            end
            StScanB:
            begin
                if (!rv_reg && ptr_reg >= n_use)
                begin
                    st_next = StFinal;
                end
            end
            StFinal: st_next = StOut;
            StOut:   st_next = StIdle;
            default: st_next = StIdle;
        endcase
        if (st_reg == StIdle && start)
        begin
            st_next = (item.mode == ModeInit) ? StWipe : StScanA;
        end
    end

    // Slot of the row whose read is issued in pass A.
    logic [SlotW-1:0] pa_addr;
    assign pa_addr = ptr_reg[SlotW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= StIdle;
            used_reg      <= '0;
            last_hash_reg <= '0;
            ptr_reg       <= '0;
            rv_reg        <= 1'b0;
            rs_reg        <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= 1'b0;
            case (st_reg)
                StIdle:
                begin
                    rv_reg <= 1'b0;
                    if (start)
                    begin
                        ptr_reg <= (item.mode == ModeInit) ? '0 : CountW'(1);
                        rv_reg  <= 1'b0;
                        // Slot 0 is read first; its row feeds self update/tick.
                        if (item.mode != ModeInit)
                        begin
                            ptr_reg <= '0;
                        end
                    end
                end
                StWipe:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == CountW'(MaxPeers - 1))
                    begin
                        ptr_reg  <= '0;
                        used_reg <= CountW'(1);
                    end
                end
                StScanA:
                begin
                    rv_reg <= ptr_reg < n_use;
                    rs_reg <= pa_addr;
                    if (ptr_reg < n_use)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    if (st_next == StApply)
                    begin
                        ptr_reg <= '0;
                    end
                end
                StApply:
                begin
                    ptr_reg <= '0;
                    rv_reg  <= 1'b0;
                    if ((it_reg.mode == ModeHb && !found_reg && used_reg < CountW'(MaxPeers))
                        || (it_reg.mode == ModeSeed && it_reg.peer_mac != own_mac_reg
                            && !it_reg.status_flags[1] && !found_reg
                            && used_reg < CountW'(MaxPeers)))
                    begin
                        used_reg <= used_reg + 1'b1;
                    end
                    if (it_reg.mode == ModeClear)
                    begin
                        used_reg <= '0;
                    end
                end
                StScanB:
                begin
                    rv_reg <= ptr_reg < n_use;
                    rs_reg <= ptr_reg[SlotW-1:0];
                    if (ptr_reg < n_use)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                StFinal:
                begin
                    if (res_c.sync_sent)
                    begin
                        last_hash_reg <= fhash;
                    end
                    done_reg <= 1'b1;
                end
                default: rv_reg <= 1'b0;
            endcase
        end
    end

    // Datapath accumulators for both passes.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            StIdle:
            begin
                it_reg         <= item;
                found_reg      <= 1'b0;
                fidx_reg       <= '0;
                dead_found_reg <= 1'b0;
                changed_reg    <= 1'b0;
                gw_reg         <= '0;
                newp_reg       <= 1'b0;
                full_reg       <= 1'b0;
                sync_reg       <= 1'b0;
            end
            StScanA:
            begin
                if (rv_reg)
                begin
                    if (rs_reg == '0)
                    begin
                        gw_reg <= rrow.battery;
                    end
                    if (!found_reg && rrow.mac == it_reg.peer_mac)
                    begin
                        found_reg      <= 1'b1;
                        fidx_reg       <= rs_reg;
                        dead_found_reg <= rrow.status[1];
                    end
                    if (it_reg.mode == ModeTick && rs_reg != '0 && !rrow.status[1]
                        && age > stale_reg)
                    begin
                        changed_reg <= 1'b1;
                    end
                end
            end
            StApply:
            begin
                case (it_reg.mode)
                    ModeHb:
                    begin
                        if (!found_reg && used_reg >= CountW'(MaxPeers))
                        begin
                            full_reg <= 1'b1;
                        end
                        else
                        begin
                            newp_reg <= !found_reg;
                            sync_reg <= !found_reg || dead_found_reg;
                        end
                    end
                    ModeTick: sync_reg <= changed_reg;
                    ModeSeed:
                    begin
                        if (it_reg.peer_mac != own_mac_reg && !it_reg.status_flags[1]
                            && !found_reg)
                        begin
                            if (used_reg >= CountW'(MaxPeers))
                            begin
                                full_reg <= 1'b1;
                            end
                            else
                            begin
                                newp_reg <= 1'b1;
                            end
                        end
                        sync_reg <= it_reg.seed_last;
                    end
                    default: sync_reg <= 1'b0;
                endcase
            end
            default: newp_reg <= newp_reg;
        endcase
        // Pass B starts from clean accumulators.
        if (st_reg == StApply || st_reg == StWipe)
        begin
            found_reg <= 1'b0;
            hash_reg  <= '0;
            alive_reg <= '0;
            best_reg  <= '0;
            ebat_reg  <= '0;
            eflg_reg  <= '0;
        end
        if (st_reg == StScanB && rv_reg)
        begin
            hash_reg <= hash_reg ^ (32'(rrow.status) << rs_reg);
            if (!rrow.status[1])
            begin
                alive_reg <= alive_reg + 1'b1;
                if (rs_reg != '0 && rrow.battery > best_reg)
                begin
                    best_reg <= rrow.battery;
                end
            end
            if (!found_reg && rrow.mac == it_reg.peer_mac)
            begin
                found_reg <= 1'b1;
                fidx_reg  <= rs_reg;
                ebat_reg  <= rrow.battery;
                eflg_reg  <= rrow.status;
            end
        end
        if (st_reg == StFinal)
        begin
            res_reg <= res_c;
        end
    end

    assign busy   = st_reg != StIdle;
    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

// ===== sv/pta_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pta_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
